// ----- rtl/tcmi_pkg.sv -----
package tcmi_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_STEP    = 2'd0;
  localparam logic [1:0] FUNC_RESET   = 2'd1;
  localparam logic [1:0] FUNC_WRITE_X = 2'd2;
  localparam logic [1:0] FUNC_WRITE_Y = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_COUPLING = 2'd0;
  localparam logic [1:0] REG_X_START  = 2'd1;
  localparam logic [1:0] REG_Y_START  = 2'd2;
  localparam logic [1:0] REG_ECHO     = 2'd3;

  // Register reset values, Q8.24.
  localparam logic signed [31:0] COUPLING_RST = 32'sd21139292;
  localparam logic signed [31:0] X_START_RST  = 32'sd13035897;
  localparam logic signed [31:0] Y_START_RST  = 32'sd20132659;

  // Fixed-point constants.
  localparam logic signed [31:0] TWO_PI_Q24    = 32'sd105414357;
  localparam logic signed [33:0] TWO_PI_WIDE   = 34'sd105414357;
  localparam logic [31:0]        PHASE_PER_RAD = 32'd683565276;
  localparam logic [31:0]        HALF_PI_Q30   = 32'd1686629713;
  localparam logic [31:0]        ONE_Q30       = 32'd1073741824;
  localparam logic [31:0]        HALF_TURN     = 32'h8000_0000;
  localparam logic [30:0]        QUARTER_TURN  = 31'h4000_0000;

  // Number of Taylor terms and the mod reduction steps.
  localparam int unsigned POLY_TERMS = 5;
  localparam int unsigned MOD_STEPS  = 7;

  // Divisors of the sine series and their reciprocals floor(2^32 / k).
  localparam logic [7:0] POLY_DIVISOR [POLY_TERMS] = '{
    8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };

  localparam logic [31:0] POLY_RECIP [POLY_TERMS] = '{
    32'(64'h1_0000_0000 / 64'd110),
    32'(64'h1_0000_0000 / 64'd72),
    32'(64'h1_0000_0000 / 64'd42),
    32'(64'h1_0000_0000 / 64'd20),
    32'(64'h1_0000_0000 / 64'd6)
  };

endpackage

// ----- rtl/torus_chaotic_map_iterator.sv -----
// Chaotic torus map iterator. The block holds two angles x and y as signed
// Q8.24 words and, on each advance, computes new_x = (x + coupling*sin(y))
// rem 2*pi and new_y = (x + y) rem 2*pi, both from the old x, with the
// remainder truncating so it keeps the sign of its dividend. A step word
// first emits the current angles on the output channel and then advances;
// a reset word reloads the start angles; a write word sets x or y and,
// with echo_on_write set, also emits and advances. All products come
// from one shared 33x33 signed multiplier under a small sequencer that
// runs the phase product, the fold to a quarter turn, a five term sine
// series whose divisions by small constants are done by reciprocal
// multiplication with a one-step correction, the coupling product, and
// finally two shift-and-subtract remainders of seven steps each. A word
// that advances keeps the block busy until the new angles are stored, so
// no other word is accepted meanwhile; while the block is idle, reset
// words and writes without echo are taken every cycle. The input is also
// held off while a finished result still waits at the output.
module torus_chaotic_map_iterator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import tcmi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PHASE,
    S_FOLD,
    S_RAD,
    S_RSQ,
    S_DVD,
    S_DIV_M,
    S_DIV_Q,
    S_DIV_C,
    S_POLY,
    S_SIN,
    S_SGN,
    S_TERM,
    S_TRUNC,
    S_SUM,
    S_MOD
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] coupling;
  logic signed [31:0] x_start;
  logic signed [31:0] y_start;
  logic               echo_on_write;

  // Map state.
  logic signed [31:0] x_angle;
  logic signed [31:0] y_angle;

  // Datapath registers of the sequencer.
  logic signed [65:0] prod;     // registered multiplier result
  logic               neg;      // sign of the sine
  logic [30:0]        r;        // folded phase, then radians in Q1.30
  logic [31:0]        r2;       // r squared, Q2.30
  logic [30:0]        t;        // running series term, Q1.30
  logic [31:0]        dvd;      // dividend of the current series division
  logic [31:0]        quo;      // estimated quotient before correction
  logic [2:0]         kidx;     // series term index
  logic signed [31:0] sv;       // signed sine, Q2.30
  logic signed [33:0] term;     // coupling*sine in Q10.24
  logic signed [33:0] rem;      // running remainder
  logic [2:0]         mcnt;     // remainder step, counts down
  logic               mod_y;    // second remainder (for y) in progress
  logic signed [31:0] x_new;

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  // Combinational helpers.
  logic               in_acc;
  logic [31:0]        ph;
  logic [30:0]        q_fold;
  logic [31:0]        div_rem;
  logic               div_fix;
  logic [31:0]        t_wide;
  logic signed [65:0] biased;
  logic signed [33:0] mod_sub;
  logic signed [33:0] rem_next;

  // The block takes no new word while it is busy, or while the output holds a
  // word that is not leaving in this cycle.
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign mul_p = mul_a * mul_b;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PHASE: begin
        mul_a = 33'(y_angle);
        mul_b = {1'b0, PHASE_PER_RAD};
      end
      S_RAD: begin
        mul_a = {2'b00, r};
        mul_b = {1'b0, HALF_PI_Q30};
      end
      S_RSQ: begin
        mul_a = {2'b00, prod[60:30]};
        mul_b = {2'b00, prod[60:30]};
      end
      S_DIV_M: begin
        mul_a = {1'b0, dvd};
        mul_b = {1'b0, POLY_RECIP[kidx]};
      end
      S_DIV_Q: begin
        mul_a = {1'b0, prod[63:32]};
        mul_b = {25'd0, POLY_DIVISOR[kidx]};
      end
      S_POLY: begin
        mul_a = {1'b0, r2};
        mul_b = {2'b00, t};
      end
      S_SIN: begin
        mul_a = {2'b00, r};
        mul_b = {2'b00, t};
      end
      S_TERM: begin
        mul_a = 33'(coupling);
        mul_b = 33'(sv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Phase is a 32-bit fraction of a turn. Its top bit gives the sign of the
  // sine, and the second half of each half turn is mirrored onto the first.
  assign ph = prod[55:24];
  always_comb begin
    q_fold = ph[30:0];
    if (ph[30:0] > QUARTER_TURN) begin
      q_fold = 31'(HALF_TURN - {1'b0, ph[30:0]});
    end
  end

  // The reciprocal estimate is at most one short of the true quotient.
  assign div_rem = dvd - prod[31:0];
  assign div_fix = (div_rem >= {24'd0, POLY_DIVISOR[kidx]});
  assign t_wide  = ONE_Q30 - quo - {31'd0, div_fix};

  // Division of the coupling product by 2^30 truncates toward zero.
  assign biased = prod[65] ? (prod + 66'sd1073741823) : prod;

  // One restoring step of the truncating remainder, working on the signed
  // value directly so the remainder keeps the sign of the dividend.
  assign mod_sub = TWO_PI_WIDE <<< mcnt;
  always_comb begin
    rem_next = rem;
    if (!rem[33]) begin
      if (rem >= mod_sub) begin
        rem_next = rem - mod_sub;
      end
    end else begin
      if (rem <= -mod_sub) begin
        rem_next = rem + mod_sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      coupling      <= COUPLING_RST;
      x_start       <= X_START_RST;
      y_start       <= Y_START_RST;
      echo_on_write <= 1'b0;
      x_angle       <= X_START_RST;
      y_angle       <= Y_START_RST;
      kidx          <= '0;
      mcnt          <= '0;
      mod_y         <= 1'b0;
    end else begin
      prod <= mul_p;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_COUPLING: coupling      <= $signed(cfg_data);
          REG_X_START:  x_start       <= $signed(cfg_data);
          REG_Y_START:  y_start       <= $signed(cfg_data);
          REG_ECHO:     echo_on_write <= cfg_data[0];
          default:      ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (func)
              FUNC_STEP: begin
                x_out     <= x_angle;
                y_out     <= y_angle;
                out_valid <= 1'b1;
                state     <= S_PHASE;
              end
              FUNC_RESET: begin
                x_angle <= x_start;
                y_angle <= y_start;
              end
              FUNC_WRITE_X: begin
                x_angle <= value;
                if (echo_on_write) begin
                  x_out     <= value;
                  y_out     <= y_angle;
                  out_valid <= 1'b1;
                  state     <= S_PHASE;
                end
              end
              FUNC_WRITE_Y: begin
                y_angle <= value;
                if (echo_on_write) begin
                  x_out     <= x_angle;
                  y_out     <= value;
                  out_valid <= 1'b1;
                  state     <= S_PHASE;
                end
              end
              default: ;
            endcase
          end
        end
        S_PHASE: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          neg   <= ph[31];
          r     <= q_fold;
          state <= S_RAD;
        end
        S_RAD: begin
          state <= S_RSQ;
        end
        S_RSQ: begin
          r     <= prod[60:30];
          kidx  <= '0;
          state <= S_DVD;
        end
        S_DVD: begin
          dvd <= prod[61:30];
          if (kidx == '0) begin
            r2 <= prod[61:30];
          end
          state <= S_DIV_M;
        end
        S_DIV_M: begin
          state <= S_DIV_Q;
        end
        S_DIV_Q: begin
          quo   <= prod[63:32];
          state <= S_DIV_C;
        end
        S_DIV_C: begin
          t <= t_wide[30:0];
          if (kidx == 3'(POLY_TERMS - 1)) begin
            state <= S_SIN;
          end else begin
            kidx  <= kidx + 3'd1;
            state <= S_POLY;
          end
        end
        S_POLY: begin
          state <= S_DVD;
        end
        S_SIN: begin
          state <= S_SGN;
        end
        S_SGN: begin
          sv    <= neg ? -$signed({1'b0, prod[60:30]}) : $signed({1'b0, prod[60:30]});
          state <= S_TERM;
        end
        S_TERM: begin
          state <= S_TRUNC;
        end
        S_TRUNC: begin
          term  <= 34'(biased >>> 30);
          state <= S_SUM;
        end
        S_SUM: begin
          rem   <= 34'(x_angle) + term;
          mcnt  <= 3'(MOD_STEPS - 1);
          mod_y <= 1'b0;
          state <= S_MOD;
        end
        S_MOD: begin
          if (mcnt == '0) begin
            if (!mod_y) begin
              // New x is ready; the y sum still uses the old x.
              x_new <= rem_next[31:0];
              rem   <= 34'(x_angle) + 34'(y_angle);
              mcnt  <= 3'(MOD_STEPS - 1);
              mod_y <= 1'b1;
            end else begin
              x_angle <= x_new;
              y_angle <= rem_next[31:0];
              mod_y   <= 1'b0;
              state   <= S_IDLE;
            end
          end else begin
            rem  <= rem_next;
            mcnt <= mcnt - 3'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result word only appears as the answer to a word taken while idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_IDLE) && $past(in_valid))
    else $error("result word appeared without an accepted input word");

  // A step word emits the angles held before it.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func == FUNC_STEP)) |=>
      out_valid && (x_out == $past(x_angle)) && (y_out == $past(y_angle)))
    else $error("step word did not emit the current angles");

  // The reciprocal estimate never needs more than one correction.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_C) |-> (33'(div_rem) < (33'(POLY_DIVISOR[kidx]) << 1)))
    else $error("series division estimate off by more than one");

  // After an advance both angles lie strictly inside plus or minus 2*pi.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_MOD) && mod_y && (mcnt == '0)) |=>
      (x_angle < TWO_PI_Q24) && (x_angle > -TWO_PI_Q24) &&
      (y_angle < TWO_PI_Q24) && (y_angle > -TWO_PI_Q24))
    else $error("angle left the 2*pi range after an advance");

endmodule

// ----- sim/torus_chaotic_map_iterator_tb.sv -----
module torus_chaotic_map_iterator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcmi_pkg::*;

  // A word on the input channel and the pair of angles that a step emits.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } map_word_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } angle_pair_t;

  // After the last emitted pair the block may still be busy advancing the
  // map, so this many cycles let it settle completely.
  localparam int SETTLE_CYCLES  = 64;
  localparam int WORDS_PER_RUN  = 280;
  localparam int RUNS           = 6;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int MAX_REPORTS    = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_STEP;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_COUPLING;
  logic [31:0]        cfg_data = '0;

  torus_chaotic_map_iterator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .y_out     (y_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's registers and map state. Reset is applied
  // only once at the start, so the reset values serve as initial values.
  logic signed [31:0] gain   = COUPLING_RST;
  logic signed [31:0] x_home = X_START_RST;
  logic signed [31:0] y_home = Y_START_RST;
  logic               echo_en = 1'b0;
  logic signed [31:0] ang_x  = X_START_RST;
  logic signed [31:0] ang_y  = Y_START_RST;

  map_word_t   pending_words [$];
  angle_pair_t emitted_angles [$];
  map_word_t   next_word;

  int err_count     = 0;
  int pairs_seen    = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  logic hold_done   = 1'b0;

  // Sine of a Q8.24 angle as a signed Q2.30 value. The angle is turned into
  // a 32-bit phase (fraction of a full turn, wrapping freely), folded into
  // the first quarter turn, and the magnitude comes from a nested Taylor
  // series evaluated in unsigned Q2.30 with flooring divisions.
  function automatic longint map_sine_q30(input logic signed [31:0] ang);
    longint      prod;
    logic [31:0] ph;
    logic [63:0] q, r, r2, t, s;
    prod = longint'(ang) * longint'(PHASE_PER_RAD);
    ph   = prod[55:24];
    q    = {33'b0, ph[30:0]};
    if (q > 64'h4000_0000) q = 64'h8000_0000 - q;
    r  = (q * 64'(HALF_PI_Q30)) >> 30;
    r2 = (r * r) >> 30;
    // Starting from one, the first pass reduces to one minus r2/110.
    t  = 64'(ONE_Q30);
    t  = 64'(ONE_Q30) - ((r2 * t) >> 30) / 64'd110;
    t  = 64'(ONE_Q30) - ((r2 * t) >> 30) / 64'd72;
    t  = 64'(ONE_Q30) - ((r2 * t) >> 30) / 64'd42;
    t  = 64'(ONE_Q30) - ((r2 * t) >> 30) / 64'd20;
    t  = 64'(ONE_Q30) - ((r2 * t) >> 30) / 64'd6;
    s  = (r * t) >> 30;
    return ph[31] ? -longint'(s) : longint'(s);
  endfunction

  // Emit the present angles, then advance the map. Both new angles are
  // built from the old x; the sums are wide, and the remainder keeps the
  // sign of its dividend, as does the truncating coupling division.
  task automatic emit_and_advance();
    longint kick, nx, ny;
    angle_pair_t pair;
    pair.ax = ang_x;
    pair.ay = ang_y;
    emitted_angles.push_back(pair);
    kick  = (longint'(gain) * map_sine_q30(ang_y)) / longint'(ONE_Q30);
    nx    = (longint'(ang_x) + kick) % longint'(TWO_PI_Q24);
    ny    = (longint'(ang_x) + longint'(ang_y)) % longint'(TWO_PI_Q24);
    ang_x = nx[31:0];
    ang_y = ny[31:0];
  endtask

  // Effect of one accepted input word on the shadow state.
  task automatic apply_map_word(input logic [1:0] f, input logic signed [31:0] v);
    case (f)
      FUNC_STEP: begin
        emit_and_advance();
      end
      FUNC_RESET: begin
        ang_x = x_home;
        ang_y = y_home;
      end
      FUNC_WRITE_X: begin
        ang_x = v;
        if (echo_en) emit_and_advance();
      end
      default: begin
        ang_y = v;
        if (echo_en) emit_and_advance();
      end
    endcase
  endtask

  // Sender. Words come from the pending queue; each accepted word is fed to
  // the shadow model at the edge where it is taken. A payload is held as
  // long as the block stalls it, and idle bursts are only started right
  // after a word is loaded, so valid never looks at the stall.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) apply_map_word(func, value);
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        func     <= next_word.func;
        value    <= next_word.value;
        if ($urandom_range(99) < send_idle_pct) send_gap <= $urandom_range(7, 1);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Every accepted pair is checked against the oldest expected
  // one. The stall follows random bursts, or the long hold when it runs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        pairs_seen <= pairs_seen + 1;
        if (emitted_angles.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected word x_out %0d y_out %0d", $time, x_out, y_out);
        end else begin
          if (emitted_angles[0].ax !== x_out) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: x_out expected %0d actual %0d", $time,
                       emitted_angles[0].ax, x_out);
          end
          if (emitted_angles[0].ay !== y_out) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: y_out expected %0d actual %0d", $time,
                       emitted_angles[0].ay, y_out);
          end
          void'(emitted_angles.pop_front());
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap != 0) begin
        out_stall <= 1'b1;
        recv_gap  <= recv_gap - 1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(99) < recv_idle_pct) recv_gap <= $urandom_range(7, 1);
      end
    end
  end

  // Once, after a while, the receiver refuses output for a long stretch.
  // The sender keeps offering words meanwhile, so the block backs up and
  // has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && pairs_seen >= HOLD_AFTER) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // Write one register through the configuration channel and mirror it in
  // the shadow copy at the edge where the write takes place.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COUPLING: gain    = d;
      REG_X_START:  x_home  = d;
      REG_Y_START:  y_home  = d;
      default:      echo_en = d[0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued word is taken and every expected pair has come,
  // then let the block finish any advance still under way. The check is
  // made at the falling edge, once the sender has settled for the cycle.
  task automatic drain(input int extra);
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || emitted_angles.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic queue_word(input logic [1:0] f, input logic [31:0] v);
    map_word_t w;
    w.func  = f;
    w.value = v;
    pending_words.push_back(w);
  endtask

  // Angles of every kind: full 32-bit noise, values inside one turn either
  // way, the extremes, zero, and small values around zero.
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(2 * TWO_PI_Q24) - TWO_PI_Q24);
      2: begin
        case ($urandom_range(2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return 32'h0;
        endcase
      end
      default: return 32'($urandom_range(2047)) - 32'd1024;
    endcase
  endfunction

  initial begin
    int          n, pick, waited;
    logic [31:0] d;
    logic [1:0]  f;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings: plain steps, extreme angles
    // on both axes, the sine near a quarter turn and at a half turn, zero,
    // a negative angle, and a reload of the start angles. Steps and resets
    // carry random values that the block must ignore.
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_WRITE_X, 32'h7FFF_FFFF);
    queue_word(FUNC_WRITE_Y, 32'h8000_0000);
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_WRITE_Y, 32'sd26353589);
    queue_word(FUNC_STEP, 32'h0);
    queue_word(FUNC_WRITE_Y, -32'sd26353590);
    queue_word(FUNC_STEP, 32'hFFFF_FFFF);
    queue_word(FUNC_WRITE_Y, 32'h0);
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_WRITE_Y, 32'sd52707179);
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_RESET, $urandom);
    queue_word(FUNC_STEP, $urandom);
    drain(SETTLE_CYCLES);

    // Largest coupling with extreme start angles and echo on, so writes
    // emit and advance with the newly written angle.
    write_reg(REG_COUPLING, 32'h7FFF_FFFF);
    write_reg(REG_X_START, 32'h8000_0000);
    write_reg(REG_Y_START, 32'h7FFF_FFFF);
    write_reg(REG_ECHO, 32'hFFFF_FFFF);
    queue_word(FUNC_RESET, 32'h0);
    queue_word(FUNC_STEP, $urandom);
    queue_word(FUNC_WRITE_X, 32'h0);
    queue_word(FUNC_WRITE_Y, 32'h8000_0000);
    queue_word(FUNC_STEP, $urandom);
    drain(SETTLE_CYCLES);

    // Most negative coupling, the y start angle at zero.
    write_reg(REG_COUPLING, 32'h8000_0000);
    write_reg(REG_Y_START, 32'h0);
    queue_word(FUNC_WRITE_X, 32'h7FFF_FFFF);
    queue_word(FUNC_WRITE_Y, 32'sd13176795);
    queue_word(FUNC_RESET, $urandom);
    queue_word(FUNC_STEP, $urandom);
    drain(SETTLE_CYCLES);

    // Random runs, each under its own register settings. The coupling walks
    // through realistic gains, both extremes, zero, noise and its default.
    // Echo alternates between runs. Run 2 has no idling at all, and the
    // last run is free of idling on both sides.
    for (int run = 0; run < RUNS; run++) begin
      case (run)
        0: d = 32'($urandom_range(32'h0800_0000) - 32'h0400_0000);
        1: d = 32'h7FFF_FFFF;
        2: d = $urandom;
        3: d = 32'h8000_0000;
        4: d = 32'h0;
        default: d = COUPLING_RST;
      endcase
      write_reg(REG_COUPLING, d);
      write_reg(REG_X_START, pick_angle());
      write_reg(REG_Y_START, pick_angle());
      d    = $urandom;
      d[0] = run[0];
      write_reg(REG_ECHO, d);

      if (run == 2 || run == RUNS - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(40, 5);
        recv_idle_pct = $urandom_range(40, 5);
      end

      for (n = 0; n < WORDS_PER_RUN; n++) begin
        // Halfway through, the sender goes quiet until every expected pair
        // has been seen.
        if (n == WORDS_PER_RUN / 2) drain(0);
        pick = $urandom_range(99);
        if (pick < 60)      f = FUNC_STEP;
        else if (pick < 68) f = FUNC_RESET;
        else if (pick < 84) f = FUNC_WRITE_X;
        else                f = FUNC_WRITE_Y;
        queue_word(f, (f == FUNC_WRITE_X || f == FUNC_WRITE_Y) ? pick_angle() : $urandom);
      end
      drain(SETTLE_CYCLES);
    end

    // All words are taken by now; the remaining pairs get a bounded wait.
    waited = 0;
    while (emitted_angles.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (emitted_angles.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected words never arrived", $time, emitted_angles.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) $display("torus_chaotic_map_iterator_tb: clean");
    else $display("torus_chaotic_map_iterator_tb: errors");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_500_000;
    $display("torus_chaotic_map_iterator_tb: errors");
    $finish;
  end

endmodule
